[design/bdke_pkg.sv]
// Shared types, slot codes and date check helpers for the keypad date/time entry block.
package bdke_pkg;

   // Key command codes
   localparam logic CMD_DIGIT = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Entry slot codes
   localparam logic [3:0] SLOT_DAY_HI   = 4'd0;
   localparam logic [3:0] SLOT_DAY_LO   = 4'd1;
   localparam logic [3:0] SLOT_MONTH_HI = 4'd3;
   localparam logic [3:0] SLOT_MONTH_LO = 4'd4;
   localparam logic [3:0] SLOT_YEAR_HI  = 4'd6;
   localparam logic [3:0] SLOT_YEAR_LO  = 4'd7;
   localparam logic [3:0] SLOT_HOUR_HI  = 4'd9;
   localparam logic [3:0] SLOT_HOUR_LO  = 4'd10;
   localparam logic [3:0] SLOT_MIN_HI   = 4'd12;
   localparam logic [3:0] SLOT_MIN_LO   = 4'd13;
   localparam logic [3:0] SLOT_DONE     = 4'd14;

   localparam logic [7:0] MINUTE_MAX = 8'd59;
   localparam logic [7:0] HOUR_MAX   = 8'd23;
   localparam logic [7:0] MONTH_MAX  = 8'd12;

   typedef struct packed {
      logic       cmd;
      logic [3:0] digit;
   } req_type;

   typedef struct packed {
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] day;
      logic [7:0] month;
      logic [7:0] year;
   } date_type;

   typedef struct packed {
      logic [3:0] entry_pos;
      logic       commit;
      logic       error_flag;
      date_type   date;
   } rsp_type;

   // high nibble * 10 + low nibble; at most 165, fits 8 bits
   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {4'h0, b[7:4]};
      lo = {4'h0, b[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

   function automatic logic [4:0] month_days(input logic [7:0] month, input logic leap);
      logic [4:0] days;
      days = 5'd0;
      unique case (month)
         8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: days = 5'd31;
         8'd4, 8'd6, 8'd9, 8'd11:                   days = 5'd30;
         8'd2:                                      days = leap ? 5'd29 : 5'd28;
         default:                                   days = 5'd0;
      endcase
      return days;
   endfunction

endpackage

[design/bdke_channels.sv]
// Valid/ready channel interfaces for keypad requests and entry results.
interface bdke_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [3:0] digit;

   modport source (output valid, output cmd, output digit, input ready);
   modport sink   (input valid, input cmd, input digit, output ready);
endinterface

interface bdke_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] entry_pos;
   logic       commit;
   logic       error_flag;
   logic [7:0] minute_bcd;
   logic [7:0] hour_bcd;
   logic [7:0] day_bcd;
   logic [7:0] month_bcd;
   logic [7:0] year_bcd;

   modport source (output valid, output entry_pos, output commit, output error_flag,
                   output minute_bcd, output hour_bcd, output day_bcd,
                   output month_bcd, output year_bcd, input ready);
   modport sink   (input valid, input entry_pos, input commit, input error_flag,
                   input minute_bcd, input hour_bcd, input day_bcd,
                   input month_bcd, input year_bcd, output ready);
endinterface

[design/bcd_datetime_keypad_entry.sv]
// A taken request waits in the input register, and its result is then held in the output register.
// Throughput: one request per cycle; the input and result registers each stall only
// when the result side holds off ready.
// The entry state update is a single registered step, so the next request sees it at once.
// Reset (synchronous, active high) empties both registers and clears slot, bytes and error.
module bcd_datetime_keypad_entry (
   input logic        clock,
   input logic        reset,
   bdke_req_if.sink   req_ch,
   bdke_rsp_if.source rsp_ch
);

   logic              req_valid_ff;
   logic              req_valid_in;
   bdke_pkg::req_type req_item_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   bdke_pkg::rsp_type rsp_data_ff;
   bdke_pkg::rsp_type core_result;
   logic              advance;
   logic              fire;
   logic              req_take;

   assign advance  = !rsp_valid_ff || rsp_ch.ready;
   assign fire     = req_valid_ff && advance;
   assign req_ch.ready = !req_valid_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;

   bdke_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (fire),
      .item   (req_item_ff),
      .result (core_result)
   );

   always_comb begin
      req_valid_in = req_valid_ff;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (fire) begin
         req_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.cmd   <= req_ch.cmd;
         req_item_ff.digit <= req_ch.digit;
      end
      if (fire) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.entry_pos  = rsp_data_ff.entry_pos;
   assign rsp_ch.commit     = rsp_data_ff.commit;
   assign rsp_ch.error_flag = rsp_data_ff.error_flag;
   assign rsp_ch.minute_bcd = rsp_data_ff.date.minute;
   assign rsp_ch.hour_bcd   = rsp_data_ff.date.hour;
   assign rsp_ch.day_bcd    = rsp_data_ff.date.day;
   assign rsp_ch.month_bcd  = rsp_data_ff.date.month;
   assign rsp_ch.year_bcd   = rsp_data_ff.date.year;

   a_commit_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.commit
      |-> rsp_data_ff.entry_pos == bdke_pkg::SLOT_DONE && !rsp_data_ff.error_flag)
      else $error("commit without a clean completed entry");

   a_error_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.error_flag
      |-> rsp_data_ff.entry_pos == bdke_pkg::SLOT_DONE)
      else $error("error flag reported on an incomplete entry");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_valid_ff)
      else $error("taken request lost from input register");

endmodule

[design/bdke_check.sv]
// Calendar and clock range check of an assembled BCD date and time.
module bdke_check (
   input  bdke_pkg::date_type date,
   output logic               date_ok
);

   logic [7:0] minute_val;
   logic [7:0] hour_val;
   logic [7:0] day_val;
   logic [7:0] month_val;
   logic [7:0] year_val;
   logic [4:0] days_in_month;

   always_comb begin
      minute_val = bdke_pkg::bcd_value(date.minute);
      hour_val   = bdke_pkg::bcd_value(date.hour);
      day_val    = bdke_pkg::bcd_value(date.day);
      month_val  = bdke_pkg::bcd_value(date.month);
      year_val   = bdke_pkg::bcd_value(date.year);
      // leap when the decoded year is a multiple of four
      days_in_month = bdke_pkg::month_days(month_val, year_val[1:0] == 2'b00);
      date_ok = (minute_val <= bdke_pkg::MINUTE_MAX)
             && (hour_val <= bdke_pkg::HOUR_MAX)
             && (month_val != 8'd0) && (month_val <= bdke_pkg::MONTH_MAX)
             && (day_val != 8'd0) && (day_val <= {3'b000, days_in_month});
   end

endmodule

[design/bdke_core.sv]
// Entry state: slot sequencing, BCD byte assembly, validation and sticky error.
module bdke_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  bdke_pkg::req_type  item,
   output bdke_pkg::rsp_type  result
);

   logic [3:0]         slot_ff;
   logic [3:0]         slot_in;
   bdke_pkg::date_type date_ff;
   bdke_pkg::date_type date_in;
   logic               error_ff;
   logic               error_in;
   logic               commit;
   logic [7:0]         high_byte;
   logic [7:0]         low_add;
   bdke_pkg::date_type check_date;
   logic               date_ok;

   assign high_byte = {item.digit, 4'h0};
   assign low_add   = {4'h0, item.digit};

   // check sees the minute byte as completed by this digit
   always_comb begin
      check_date        = date_ff;
      check_date.minute = date_ff.minute + low_add;
   end

   bdke_check u_check (
      .date    (check_date),
      .date_ok (date_ok)
   );

   always_comb begin
      slot_in  = slot_ff;
      date_in  = date_ff;
      error_in = error_ff;
      commit   = 1'b0;
      if (item.cmd == bdke_pkg::CMD_CLEAR) begin
         slot_in  = bdke_pkg::SLOT_DAY_HI;
         date_in  = '0;
         error_in = 1'b0;
      end else begin
         unique case (slot_ff)
            bdke_pkg::SLOT_DAY_HI: begin
               date_in.day = high_byte;
               slot_in     = bdke_pkg::SLOT_DAY_LO;
            end
            bdke_pkg::SLOT_DAY_LO: begin
               date_in.day = date_ff.day + low_add;
               slot_in     = bdke_pkg::SLOT_MONTH_HI;
            end
            bdke_pkg::SLOT_MONTH_HI: begin
               date_in.month = high_byte;
               slot_in       = bdke_pkg::SLOT_MONTH_LO;
            end
            bdke_pkg::SLOT_MONTH_LO: begin
               date_in.month = date_ff.month + low_add;
               slot_in       = bdke_pkg::SLOT_YEAR_HI;
            end
            bdke_pkg::SLOT_YEAR_HI: begin
               date_in.year = high_byte;
               slot_in      = bdke_pkg::SLOT_YEAR_LO;
            end
            bdke_pkg::SLOT_YEAR_LO: begin
               date_in.year = date_ff.year + low_add;
               slot_in      = bdke_pkg::SLOT_HOUR_HI;
            end
            bdke_pkg::SLOT_HOUR_HI: begin
               date_in.hour = high_byte;
               slot_in      = bdke_pkg::SLOT_HOUR_LO;
            end
            bdke_pkg::SLOT_HOUR_LO: begin
               date_in.hour = date_ff.hour + low_add;
               slot_in      = bdke_pkg::SLOT_MIN_HI;
            end
            bdke_pkg::SLOT_MIN_HI: begin
               date_in.minute = high_byte;
               slot_in        = bdke_pkg::SLOT_MIN_LO;
            end
            bdke_pkg::SLOT_MIN_LO: begin
               date_in.minute = check_date.minute;
               slot_in        = bdke_pkg::SLOT_DONE;
               if (date_ok) begin
                  commit = 1'b1;
               end else begin
                  error_in = 1'b1;
               end
            end
            default: begin
               // entry complete: further digits are dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= bdke_pkg::SLOT_DAY_HI;
         date_ff  <= '0;
         error_ff <= 1'b0;
      end else if (step) begin
         slot_ff  <= slot_in;
         date_ff  <= date_in;
         error_ff <= error_in;
      end
   end

   always_comb begin
      result.entry_pos  = slot_in;
      result.commit     = commit;
      result.error_flag = error_in;
      result.date       = date_in;
   end

   a_slot_legal: assert property (@(posedge clock) disable iff (reset)
      slot_ff != 4'd2 && slot_ff != 4'd5 && slot_ff != 4'd8
      && slot_ff != 4'd11 && slot_ff != 4'd15)
      else $error("entry slot holds an unused code");

   a_error_only_done: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> slot_ff == bdke_pkg::SLOT_DONE)
      else $error("error flag set before entry completed");

endmodule

[test/bdke_entry_scoreboard.sv]
// Scoreboard for the keypad date/time entry block: predicts every result and compares it.
`timescale 1ns / 1ps

module bdke_entry_scoreboard
   import bdke_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_cmd,
   input  logic [3:0] req_digit,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [3:0] rsp_entry_pos,
   input  logic       rsp_commit,
   input  logic       rsp_error_flag,
   input  logic [7:0] rsp_minute_bcd,
   input  logic [7:0] rsp_hour_bcd,
   input  logic [7:0] rsp_day_bcd,
   input  logic [7:0] rsp_month_bcd,
   input  logic [7:0] rsp_year_bcd,
   output int         mismatch_count,
   output int         pending_count,
   output int         commit_count,
   output int         reject_count
);

   // predicted entry state
   logic [3:0] slot_q;
   date_type   date_q;
   logic       err_q;

   rsp_type    expected_rsp_q[$];

   function automatic int unsigned bcd_to_int(input logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
   endfunction

   function automatic int unsigned days_of(input int unsigned mo, input int unsigned yr);
      case (mo)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return (yr % 4 == 0) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic bit date_passes(input date_type d);
      int unsigned dy;
      int unsigned mo;
      dy = bcd_to_int(d.day);
      mo = bcd_to_int(d.month);
      return bcd_to_int(d.minute) <= MINUTE_MAX && bcd_to_int(d.hour) <= HOUR_MAX &&
             mo >= 1 && mo <= MONTH_MAX &&
             dy >= 1 && dy <= days_of(mo, bcd_to_int(d.year));
   endfunction

   // advances the predicted state by one key and returns the result it should produce
   function automatic rsp_type apply_key(input logic cmd, input logic [3:0] digit);
      rsp_type    r;
      logic [7:0] hi;
      hi = {digit, 4'h0};
      r.commit = 1'b0;
      if (cmd == CMD_CLEAR) begin
         slot_q = SLOT_DAY_HI;
         date_q = '0;
         err_q  = 1'b0;
      end else begin
         case (slot_q)
            SLOT_DAY_HI: begin
               date_q.day = hi;
               slot_q = SLOT_DAY_LO;
            end
            SLOT_DAY_LO: begin
               date_q.day = date_q.day + 8'(digit);
               slot_q = SLOT_MONTH_HI;
            end
            SLOT_MONTH_HI: begin
               date_q.month = hi;
               slot_q = SLOT_MONTH_LO;
            end
            SLOT_MONTH_LO: begin
               date_q.month = date_q.month + 8'(digit);
               slot_q = SLOT_YEAR_HI;
            end
            SLOT_YEAR_HI: begin
               date_q.year = hi;
               slot_q = SLOT_YEAR_LO;
            end
            SLOT_YEAR_LO: begin
               date_q.year = date_q.year + 8'(digit);
               slot_q = SLOT_HOUR_HI;
            end
            SLOT_HOUR_HI: begin
               date_q.hour = hi;
               slot_q = SLOT_HOUR_LO;
            end
            SLOT_HOUR_LO: begin
               date_q.hour = date_q.hour + 8'(digit);
               slot_q = SLOT_MIN_HI;
            end
            SLOT_MIN_HI: begin
               date_q.minute = hi;
               slot_q = SLOT_MIN_LO;
            end
            SLOT_MIN_LO: begin
               date_q.minute = date_q.minute + 8'(digit);
               slot_q = SLOT_DONE;
               if (date_passes(date_q)) begin
                  r.commit = 1'b1;
                  commit_count++;
               end else begin
                  err_q = 1'b1;
                  reject_count++;
               end
            end
            default: ; // entry complete: digit ignored
         endcase
      end
      r.entry_pos  = slot_q;
      r.error_flag = err_q;
      r.date       = date_q;
      return r;
   endfunction

   task automatic log_mismatch(input string what, input rsp_type want, input rsp_type got);
      if (mismatch_count < 10) begin
         $display("%0t %s: exp pos %0d commit %b err %b  got pos %0d commit %b err %b",
                  $realtime, what, want.entry_pos, want.commit, want.error_flag,
                  got.entry_pos, got.commit, got.error_flag);
         $display("   exp min %h hr %h day %h mon %h yr %h  got min %h hr %h day %h mon %h yr %h",
                  want.date.minute, want.date.hour, want.date.day, want.date.month,
                  want.date.year, got.date.minute, got.date.hour, got.date.day,
                  got.date.month, got.date.year);
      end
      mismatch_count++;
   endtask

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      commit_count   = 0;
      reject_count   = 0;
      slot_q = SLOT_DAY_HI;
      date_q = '0;
      err_q  = 1'b0;
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         slot_q = SLOT_DAY_HI;
         date_q = '0;
         err_q  = 1'b0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.entry_pos   = rsp_entry_pos;
            got.commit      = rsp_commit;
            got.error_flag  = rsp_error_flag;
            got.date.minute = rsp_minute_bcd;
            got.date.hour   = rsp_hour_bcd;
            got.date.day    = rsp_day_bcd;
            got.date.month  = rsp_month_bcd;
            got.date.year   = rsp_year_bcd;
            if (expected_rsp_q.size() == 0) begin
               log_mismatch("result with no request pending", '0, got);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.entry_pos !== want.entry_pos || got.commit !== want.commit ||
                   got.error_flag !== want.error_flag ||
                   got.date.minute !== want.date.minute || got.date.hour !== want.date.hour ||
                   got.date.day !== want.date.day || got.date.month !== want.date.month ||
                   got.date.year !== want.date.year)
                  log_mismatch("result mismatch", want, got);
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(apply_key(req_cmd, req_digit));
      end
      pending_count <= expected_rsp_q.size();
   end

endmodule

[test/tb.sv]
// Top of the keypad date/time entry testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
   import bdke_pkg::*;

   // longest honest quiet spell: the longest sender gap plus a long receiver stall, many times over
   localparam int STUCK_LIMIT = 2000;
   localparam int ITEM_TARGET = 1400;

   logic clock;
   logic reset;

   bdke_req_if req_ch ();
   bdke_rsp_if rsp_ch ();

   int mismatch_count;
   int pending_count;
   int commit_count;
   int reject_count;

   int burst_left;
   int sent_count;
   int clear_count;
   int stuck_cycles;
   int stall_mode;
   int stall_left;

   bcd_datetime_keypad_entry dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bdke_entry_scoreboard entry_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_cmd        (req_ch.cmd),
      .req_digit      (req_ch.digit),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_entry_pos  (rsp_ch.entry_pos),
      .rsp_commit     (rsp_ch.commit),
      .rsp_error_flag (rsp_ch.error_flag),
      .rsp_minute_bcd (rsp_ch.minute_bcd),
      .rsp_hour_bcd   (rsp_ch.hour_bcd),
      .rsp_day_bcd    (rsp_ch.day_bcd),
      .rsp_month_bcd  (rsp_ch.month_bcd),
      .rsp_year_bcd   (rsp_ch.year_bcd),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .commit_count   (commit_count),
      .reject_count   (reject_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // result side: switches between always-ready, random, heavy-stall and periodic patterns
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= ($urandom_range(0, 1) == 0);
         2:       rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ch.ready <= (stall_left % 5 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  STUCK_LIMIT, pending_count);
         $display("tb failed");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the request is taken
   task automatic send_key(input logic cmd, input logic [3:0] digit, input bit counted = 1'b1);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.digit <= digit;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      if (counted) sent_count++;
      if (cmd == CMD_CLEAR) clear_count++;
      @(negedge clock);
   endtask

   task automatic send_clear();
      send_key(CMD_CLEAR, 4'($urandom_range(0, 15)));
   endtask

   // ten digits, most significant nibble first
   task automatic send_digits(input logic [39:0] keys);
      for (int i = 9; i >= 0; i--)
         send_key(CMD_DIGIT, keys[i*4 +: 4]);
   endtask

   // day, month, year, hour, minute as decimal; a few digits may be swapped for 10..15
   task automatic send_date(input int unsigned dy, input int unsigned mo, input int unsigned yr,
                            input int unsigned hr, input int unsigned mi);
      int unsigned vals[5];
      logic [3:0]  d;
      vals = '{dy, mo, yr, hr, mi};
      for (int i = 0; i < 5; i++) begin
         for (int k = 0; k < 2; k++) begin
            d = 4'((k == 0) ? vals[i] / 10 : vals[i] % 10);
            if ($urandom_range(0, 39) == 0)
               d = 4'($urandom_range(10, 15));
            send_key(CMD_DIGIT, d);
         end
      end
   endtask

   initial begin
      int unsigned pick;
      int unsigned dy;
      int unsigned mo;
      int unsigned yr;
      int unsigned hr;
      int unsigned mi;
      int unsigned dmax;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd   = CMD_DIGIT;
      req_ch.digit = 4'h0;
      rsp_ch.ready = 1'b0;
      stall_mode   = 0;
      stall_left   = 0;
      stuck_cycles = 0;
      burst_left   = 0;
      sent_count   = 0;
      clear_count  = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: valid leap-day entry at the last hour and minute of the day, ignored extra digit,
      // all-invalid entry with digits above nine, clears with extreme digit fields
      send_key(CMD_CLEAR, 4'h0);
      send_digits(40'h2902242359);
      send_key(CMD_DIGIT, 4'h9, 1'b0);
      send_key(CMD_CLEAR, 4'hF);
      send_digits(40'hFF13992460);
      send_key(CMD_DIGIT, 4'h0, 1'b0);
      send_key(CMD_CLEAR, 4'hA);

      while (sent_count < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 9) == 0)
               mo = ($urandom_range(0, 1) == 0) ? 0 : 13;
            else
               mo = $urandom_range(1, 12);
            yr = $urandom_range(0, 99);
            case (mo)
               2:              dmax = (yr % 4 == 0) ? 29 : 28;
               4, 6, 9, 11:    dmax = 30;
               default:        dmax = 31;
            endcase
            case ($urandom_range(0, 5))
               0:       dy = dmax;
               1:       dy = dmax + 1;
               2:       dy = ($urandom_range(0, 1) == 0) ? 0 : 29;
               default: dy = $urandom_range(1, dmax);
            endcase
            hr = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 29) : $urandom_range(0, 23);
            mi = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
            send_date(dy, mo, yr, hr, mi);
            repeat ($urandom_range(0, 2))
               send_key(CMD_DIGIT, 4'($urandom_range(0, 15)), 1'b0);
            send_clear();
         end else if (pick < 85) begin
            // entry abandoned part way
            repeat ($urandom_range(1, 9))
               send_key(CMD_DIGIT, 4'($urandom_range(0, 9)));
            send_clear();
         end else begin
            repeat ($urandom_range(1, 12))
               send_key(($urandom_range(0, 3) == 0) ? CMD_CLEAR : CMD_DIGIT,
                        4'($urandom_range(0, 15)));
            send_clear();
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d keypad requests (%0d clears); %0d entries committed, %0d rejected.",
               sent_count, clear_count, commit_count, reject_count);
      $display("Result mismatches: %0d", mismatch_count);
      if (mismatch_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

[bcd_datetime_keypad_entry.f]
design/bdke_pkg.sv
design/bdke_channels.sv
design/bdke_check.sv
design/bdke_core.sv
design/bcd_datetime_keypad_entry.sv
test/bdke_entry_scoreboard.sv
test/tb.sv
